>>> hdl/jhd_pkg.sv
// ----------------------------------------------------------------------------
// jhd_pkg
// Shared types and constants of the JPEG Huffman symbol decoder.
// ----------------------------------------------------------------------------
package jhd_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_INSERT  = 2'd1,
    ACT_DATA    = 2'd2,
    ACT_RESTART = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_INS_OK  = 3'd0,
    KIND_INS_REJ = 3'd1,
    KIND_SYMBOL  = 3'd2,
    KIND_INVALID = 3'd3,
    KIND_EOI     = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_BIT   = 3'd1,
    ST_READ  = 3'd2,
    ST_EMIT  = 3'd3,
    ST_FLUSH = 3'd4
  } state_t;

  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_00  = 8'h00;
  localparam logic [7:0] BYTE_EOI = 8'hD9;

endpackage

>>> hdl/jpeg_huffman_symbol_decoder.sv
// ----------------------------------------------------------------------------
// jpeg_huffman_symbol_decoder
// Canonical Huffman table loader and bit-serial symbol decoder.
// ----------------------------------------------------------------------------
// Clear, insert, restart and data bytes that decode nothing (a held FF, a
// dropped marker, end of image, an ended stream) keep the decoder idle: the
// next transaction can be accepted in the following cycle unless a result
// still sits stalled in the output register. A decoded data byte is read one
// bit per cycle while the output is not stalled; each bit that completes a
// code adds a symbol store read, then an emit, and a flush state at the end
// releases the byte's final result. The input stalls from the accepted byte
// until that flush is done, and longer while the output is stalled. The
// latest result of a byte is parked in a one-entry buffer until the next
// result or the byte end, so that last can be set on it. Per-length count,
// first code and first index tables are flip-flops reset with the block.
module jpeg_huffman_symbol_decoder #(
  parameter int SYMBOL_DEPTH = 256,
  parameter int MAX_CODE_LEN = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [4:0] in_code_length,
  input  logic [7:0] in_symbol_value,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_decoded_symbol,
  output logic [4:0] out_decoded_length,
  output logic       out_last
);

  localparam int AW = $clog2(SYMBOL_DEPTH);
  localparam logic [8:0] DEPTH_C = 9'(SYMBOL_DEPTH);
  localparam logic [4:0] MAXL_C  = 5'(MAX_CODE_LEN);

  // configuration
  logic jpeg_mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jpeg_mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      jpeg_mode_r <= cfg_wr_data;
    end
  end

  // table and stream state
  logic [8:0]  cnt_r [16];
  logic [15:0] fcode_r [16];
  logic [8:0]  fidx_r [16];
  logic [8:0]  loaded_r;
  logic [16:0] nfree_r;
  logic [4:0]  prev_len_r;
  logic [15:0] acc_r;
  logic [4:0]  acc_len_r;
  logic        pend_ff_r;
  logic        ended_r;

  jhd_pkg::state_t state_r, state_nxt;
  logic [7:0] byte_r;
  logic [2:0] bit_r;
  logic [4:0] sym_len_r;

  // output register
  logic       ov_r;
  logic [2:0] okind_r;
  logic [7:0] osym_r;
  logic [4:0] olen_r;
  logic       olast_r;

  // parked result of the current byte
  logic       pv_r;
  logic [2:0] pkind_r;
  logic [7:0] psym_r;
  logic [4:0] plen_r;

  logic out_free;
  assign out_free = !ov_r || !out_stall;

  logic accept;
  assign in_stall = (state_r != jhd_pkg::ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  // insert evaluation
  logic [16:0] ins_code;
  logic        ins_ok;
  logic [3:0]  ins_li;
  always_comb begin
    ins_li   = 4'(in_code_length - 5'd1);
    ins_code = (prev_len_r == 5'd0) ? 17'd0 : (nfree_r << (in_code_length - prev_len_r));
    ins_ok   = (in_code_length != 5'd0) && (in_code_length <= MAXL_C)
            && (in_code_length >= prev_len_r) && (loaded_r < DEPTH_C)
            && ({15'd0, ins_code} < (32'd1 << in_code_length));
  end

  // bit step evaluation
  logic [15:0] acc_sh;
  logic [4:0]  acc_len_inc;
  logic [3:0]  li;
  logic [15:0] off;
  logic        hit;
  logic [8:0]  hit_idx;
  always_comb begin
    acc_sh      = {acc_r[14:0], byte_r[bit_r]};
    acc_len_inc = acc_len_r + 5'd1;
    li          = 4'(acc_len_inc - 5'd1);
    off         = acc_sh - fcode_r[li];
    hit         = (cnt_r[li] != 9'd0) && (acc_sh >= fcode_r[li])
               && (off < {7'd0, cnt_r[li]});
    hit_idx     = fidx_r[li] + off[8:0];
  end

  // symbol store, read from the registered index during ST_READ
  logic [7:0]    rd_data;
  logic          ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [8:0]    idx_r;
  assign ram_we = accept && (in_action == jhd_pkg::ACT_INSERT) && ins_ok;
  assign ram_wa = loaded_r[AW-1:0];
  assign ram_ra = idx_r[AW-1:0];

  jhd_ram #(.WIDTH(8), .DEPTH(SYMBOL_DEPTH)) u_store (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(in_symbol_value),
    .rd_addr(ram_ra), .rd_data(rd_data)
  );

  logic decode_now;
  logic eoi_now;
  logic [7:0] dec_byte;
  always_comb begin
    decode_now = 1'b0;
    eoi_now    = 1'b0;
    dec_byte   = in_data_byte;
    if (in_action == jhd_pkg::ACT_DATA && !ended_r) begin
      if (!jpeg_mode_r) begin
        decode_now = 1'b1;
      end else if (pend_ff_r) begin
        decode_now = (in_data_byte == jhd_pkg::BYTE_00);
        eoi_now    = (in_data_byte == jhd_pkg::BYTE_EOI);
        dec_byte   = jhd_pkg::BYTE_FF;
      end else begin
        decode_now = (in_data_byte != jhd_pkg::BYTE_FF);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      jhd_pkg::ST_IDLE: if (accept && decode_now) state_nxt = jhd_pkg::ST_BIT;
      jhd_pkg::ST_BIT: begin
        if (out_free) begin
          if (hit) state_nxt = jhd_pkg::ST_READ;
          else if (bit_r == 3'd0) state_nxt = jhd_pkg::ST_FLUSH;
        end
      end
      jhd_pkg::ST_READ: state_nxt = jhd_pkg::ST_EMIT;
      jhd_pkg::ST_EMIT: begin
        if (out_free) state_nxt = (bit_r == 3'd0) ? jhd_pkg::ST_FLUSH : jhd_pkg::ST_BIT;
      end
      jhd_pkg::ST_FLUSH: if (!pv_r || out_free) state_nxt = jhd_pkg::ST_IDLE;
      default: state_nxt = jhd_pkg::ST_IDLE;
    endcase
  end

  // new decoder result of this cycle
  logic       res_gen;
  logic [2:0] res_kind;
  logic [7:0] res_sym;
  logic [4:0] res_len;
  logic       flush_mv;
  always_comb begin
    res_gen  = 1'b0;
    res_kind = jhd_pkg::KIND_INVALID;
    res_sym  = 8'd0;
    res_len  = 5'd0;
    if (state_r == jhd_pkg::ST_BIT && out_free && !hit && acc_len_inc >= MAXL_C) begin
      res_gen = 1'b1;
    end else if (state_r == jhd_pkg::ST_EMIT && out_free) begin
      res_gen  = 1'b1;
      res_kind = jhd_pkg::KIND_SYMBOL;
      res_sym  = (idx_r < DEPTH_C) ? rd_data : 8'd0;
      res_len  = sym_len_r;
    end
  end
  assign flush_mv = (state_r == jhd_pkg::ST_FLUSH) && pv_r && out_free;

  // output register load: single results directly, byte results via park
  logic       o_load;
  logic [2:0] o_kind;
  logic [7:0] o_sym;
  logic [4:0] o_len;
  logic       o_last;
  always_comb begin
    o_load = 1'b0;
    o_kind = pkind_r;
    o_sym  = psym_r;
    o_len  = plen_r;
    o_last = 1'b0;
    if (accept && in_action == jhd_pkg::ACT_INSERT) begin
      o_load = 1'b1;
      o_kind = ins_ok ? jhd_pkg::KIND_INS_OK : jhd_pkg::KIND_INS_REJ;
      o_sym  = 8'd0;
      o_len  = 5'd0;
      o_last = 1'b1;
    end else if (accept && eoi_now) begin
      o_load = 1'b1;
      o_kind = jhd_pkg::KIND_EOI;
      o_sym  = 8'd0;
      o_len  = 5'd0;
      o_last = 1'b1;
    end else if (res_gen && pv_r) begin
      o_load = 1'b1;
    end else if (flush_mv) begin
      o_load = 1'b1;
      o_last = 1'b1;
    end
  end

  // output and park valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      if (o_load) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      if (res_gen) pv_r <= 1'b1;
      else if (flush_mv) pv_r <= 1'b0;
    end
  end

  // output and park payloads
  always_ff @(posedge clk) begin
    if (o_load) begin
      okind_r <= o_kind;
      osym_r  <= o_sym;
      olen_r  <= o_len;
      olast_r <= o_last;
    end
    if (res_gen) begin
      pkind_r <= res_kind;
      psym_r  <= res_sym;
      plen_r  <= res_len;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= jhd_pkg::ST_IDLE;
      loaded_r   <= 9'd0;
      nfree_r    <= 17'd0;
      prev_len_r <= 5'd0;
      acc_r      <= 16'd0;
      acc_len_r  <= 5'd0;
      pend_ff_r  <= 1'b0;
      ended_r    <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        cnt_r[i]   <= 9'd0;
        fcode_r[i] <= 16'd0;
        fidx_r[i]  <= 9'd0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        jhd_pkg::ST_IDLE: begin
          if (accept) begin
            case (in_action)
              jhd_pkg::ACT_CLEAR: begin
                loaded_r <= 9'd0; nfree_r <= 17'd0; prev_len_r <= 5'd0;
                for (int i = 0; i < 16; i++) begin
                  cnt_r[i] <= 9'd0; fcode_r[i] <= 16'd0; fidx_r[i] <= 9'd0;
                end
              end
              jhd_pkg::ACT_INSERT: begin
                if (ins_ok) begin
                  if (in_code_length != prev_len_r) begin
                    fcode_r[ins_li] <= ins_code[15:0];
                    fidx_r[ins_li]  <= loaded_r;
                  end
                  cnt_r[ins_li] <= cnt_r[ins_li] + 9'd1;
                  loaded_r      <= loaded_r + 9'd1;
                  nfree_r       <= ins_code + 17'd1;
                  prev_len_r    <= in_code_length;
                end
              end
              jhd_pkg::ACT_RESTART: begin
                acc_r <= 16'd0; acc_len_r <= 5'd0; pend_ff_r <= 1'b0; ended_r <= 1'b0;
              end
              default: begin
                if (!ended_r) begin
                  if (!jpeg_mode_r) begin
                    pend_ff_r <= 1'b0;
                  end else if (pend_ff_r) begin
                    pend_ff_r <= 1'b0;
                    if (eoi_now) begin
                      ended_r <= 1'b1;
                    end
                  end else if (in_data_byte == jhd_pkg::BYTE_FF) begin
                    pend_ff_r <= 1'b1;
                  end
                end
                byte_r <= dec_byte;
                bit_r  <= 3'd7;
              end
            endcase
          end
        end
        jhd_pkg::ST_BIT: begin
          if (out_free) begin
            if (hit) begin
              idx_r     <= hit_idx;
              sym_len_r <= acc_len_inc;
              acc_r     <= 16'd0;
              acc_len_r <= 5'd0;
            end else begin
              if (acc_len_inc >= MAXL_C) begin
                acc_r <= 16'd0; acc_len_r <= 5'd0;
              end else begin
                acc_r <= acc_sh; acc_len_r <= acc_len_inc;
              end
              if (bit_r != 3'd0) bit_r <= bit_r - 3'd1;
            end
          end
        end
        jhd_pkg::ST_EMIT: begin
          if (out_free) begin
            if (bit_r != 3'd0) bit_r <= bit_r - 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = ov_r;
  assign out_kind           = okind_r;
  assign out_decoded_symbol = osym_r;
  assign out_decoded_length = olen_r;
  assign out_last           = olast_r;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != jhd_pkg::ST_IDLE) |-> in_stall) else $error("accept while busy");
  a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jhd_pkg::ST_READ) |=> (state_r == jhd_pkg::ST_EMIT)) else $error("read seq");
  a_acc_len: assert property (@(posedge clk) disable iff (!rst_n)
    acc_len_r < MAXL_C) else $error("accumulator overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_kind)
      && $stable(out_decoded_symbol) && $stable(out_decoded_length) && $stable(out_last)))
    else $error("stalled result changed");
  a_idle_no_park: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jhd_pkg::ST_IDLE) |-> !pv_r) else $error("parked result in idle");
`endif

endmodule

>>> hdl/jhd_ram.sv
// ----------------------------------------------------------------------------
// jhd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
